/* hw/rtl/ictc_pkg.sv */
// Package for the illumination change table check.
// Holds the fixed field widths, register indexes, datapath opcodes and the
// command and status structs shared by the controller and the datapath.
`timescale 1ns / 1ps

package ictc_pkg;

  localparam int RAW_W      = 16;  // input color channel
  localparam int CH_W       = 25;  // channel in Q.8 units, perturbed up to 2^25
  localparam int SUM_W      = 27;  // sum of three channels
  localparam int PROD_W     = 56;  // scaled cross products (9 * sl * c)
  localparam int ERR_W      = 16;
  localparam int FACT_W     = 17;  // 1 +/- e in Q1.16
  localparam int STEPS_CFG_W = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int K_W        = 4;   // divider bit position
  localparam int NCH        = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TABLE_STEPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REL_ERROR   = 2'd1;

  localparam logic [STEPS_CFG_W-1:0] STEPS_RESET = 10'd500;
  localparam logic [FACT_W-1:0]      ONE_Q16     = 17'h10000;
  localparam logic [32:0]            ROUND_HALF  = 33'd128;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PERT,
    OP_SUM,
    OP_MUL,
    OP_DIVINIT,
    OP_DIVSTEP,
    OP_DIVEND,
    OP_READ
  } dp_op_e;

  typedef struct packed {
    dp_op_e         op;
    logic [2:0]     idx;    // channel for OP_PERT, product for OP_MUL
    logic           axis;   // 0 = r index, 1 = g index
    logic [5:0]     mask;   // perturbation signs, Rl Ru Gl Gu Bl Bu from msb
    logic           first;  // unperturbed pass
    logic [K_W-1:0] k;      // divider bit position
  } cmd_t;

  typedef struct packed {
    logic zero;    // a divisor of the current pass is zero
    logic reject;  // a scaled ratio is above one
    logic bit_q;   // table bit read back
  } status_t;

endpackage

/* hw/rtl/illum_change_table_check.sv */
// Top level of the illumination change table check.
// Instantiates ictc_ctrl and ictc_dp; depends on ictc_pkg.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                     Payload
// command   in         start, busy                   kind_i, table_*_i, *_lit_i, *_unlit_i
// result    out        valid_o (one-cycle strobe)    possible_o, degenerate_input_o
// config    in         cfg_valid_i, cfg_ready_o      cfg_index_i, cfg_data_i
//
// A beat is taken when start is high and busy is low. A table write gives no
// result. A query runs one ratio check per pass: perturbation of the six
// channels, a sum, 4 products on the one shared multiplier, a compare, two
// restoring divisions and a registered table read. The unperturbed pass and
// up to 64 sign combinations run with early exit; a degenerate query ends in
// the unperturbed pass. The result strobe is registered and shows in the
// cycle after the deciding pass, with busy low. No clearing pass after reset:
// the table must be loaded before use; the block does not enforce this. The
// receiver cannot stall; config is always ready and must be written only
// while idle, which the block does not enforce.
module illum_change_table_check #(
  parameter int MAX_STEPS = 512
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            kind_i,
  input  logic [8:0]                      table_row_i,
  input  logic [8:0]                      table_col_i,
  input  logic                            table_bit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      red_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      green_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      blue_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      red_unlit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      green_unlit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      blue_unlit_i,
  output logic                            valid_o,
  output logic                            possible_o,
  output logic                            degenerate_input_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [ictc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ictc_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ictc_pkg::cmd_t    cmd;
  ictc_pkg::status_t status;

  // config writes go straight into the registers, so never hold them off
  assign cfg_ready_o = 1'b1;

  ictc_ctrl #(
    .MAX_STEPS(MAX_STEPS)
  ) u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .kind_i            (kind_i),
    .busy              (busy),
    .valid_o           (valid_o),
    .possible_o        (possible_o),
    .degenerate_input_o(degenerate_input_o),
    .cmd_o             (cmd),
    .status_i          (status)
  );

  ictc_dp #(
    .MAX_STEPS(MAX_STEPS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .kind_i       (kind_i),
    .table_row_i  (table_row_i),
    .table_col_i  (table_col_i),
    .table_bit_i  (table_bit_i),
    .red_lit_i    (red_lit_i),
    .green_lit_i  (green_lit_i),
    .blue_lit_i   (blue_lit_i),
    .red_unlit_i  (red_unlit_i),
    .green_unlit_i(green_unlit_i),
    .blue_unlit_i (blue_unlit_i),
    .cmd_i        (cmd),
    .status_o     (status)
  );

endmodule

/* hw/rtl/ictc_ctrl.sv */
// Controller of the illumination change table check.
// Sequences the passes of one query and owns the result strobe.
// Depends on ictc_pkg.
`timescale 1ns / 1ps

module ictc_ctrl #(
  parameter int MAX_STEPS = 512
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  logic             kind_i,
  output logic             busy,
  output logic             valid_o,
  output logic             possible_o,
  output logic             degenerate_input_o,
  output ictc_pkg::cmd_t   cmd_o,
  input  ictc_pkg::status_t status_i
);

  localparam int SW = $clog2(MAX_STEPS + 1);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b0000000001,
    ST_PERT = 10'b0000000010,
    ST_SUM  = 10'b0000000100,
    ST_MUL  = 10'b0000001000,
    ST_CMP  = 10'b0000010000,
    ST_DIVI = 10'b0000100000,
    ST_DIVS = 10'b0001000000,
    ST_DIVE = 10'b0010000000,
    ST_READ = 10'b0100000000,
    ST_WAIT = 10'b1000000000
  } state_e;

  state_e                   state_q, state_d;
  logic [2:0]               cnt_q, cnt_d;
  logic [ictc_pkg::K_W-1:0] k_q, k_d;
  logic                     axis_q, axis_d;
  logic [5:0]               m_q, m_d;
  logic                     first_q, first_d;
  logic                     valid_q, valid_d;
  logic                     poss_q, poss_d;
  logic                     deg_q, deg_d;
  logic                     miss;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    k_d     = k_q;
    axis_d  = axis_q;
    m_d     = m_q;
    first_d = first_q;
    valid_d = 1'b0;
    poss_d  = poss_q;
    deg_d   = deg_q;
    miss    = 1'b0;
    cmd_o.op    = ictc_pkg::OP_NONE;
    cmd_o.idx   = cnt_q;
    cmd_o.axis  = axis_q;
    cmd_o.mask  = m_q;
    cmd_o.first = first_q;
    cmd_o.k     = k_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.op = ictc_pkg::OP_LOAD;
          if (kind_i) begin
            state_d = ST_PERT;
            cnt_d   = 3'd0;
            m_d     = 6'd0;
            first_d = 1'b1;
          end
        end
      end
      ST_PERT: begin
        cmd_o.op = ictc_pkg::OP_PERT;
        if (cnt_q == 3'd5) begin
          cnt_d   = 3'd0;
          state_d = ST_SUM;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_SUM: begin
        cmd_o.op = ictc_pkg::OP_SUM;
        state_d  = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.op = ictc_pkg::OP_MUL;
        if (cnt_q == 3'd0 && status_i.zero) begin
          if (first_q) begin
            valid_d = 1'b1;
            poss_d  = 1'b0;
            deg_d   = 1'b1;
            state_d = ST_IDLE;
          end else begin
            miss = 1'b1;
          end
        end else if (cnt_q == 3'd3) begin
          state_d = ST_CMP;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      ST_CMP: begin
        if (status_i.reject) begin
          miss = 1'b1;
        end else begin
          axis_d  = 1'b0;
          state_d = ST_DIVI;
        end
      end
      ST_DIVI: begin
        cmd_o.op = ictc_pkg::OP_DIVINIT;
        k_d      = ictc_pkg::K_W'(SW - 1);
        state_d  = ST_DIVS;
      end
      ST_DIVS: begin
        cmd_o.op = ictc_pkg::OP_DIVSTEP;
        if (k_q == '0) begin
          state_d = ST_DIVE;
        end else begin
          k_d = k_q - 1'b1;
        end
      end
      ST_DIVE: begin
        cmd_o.op = ictc_pkg::OP_DIVEND;
        if (!axis_q) begin
          axis_d  = 1'b1;
          state_d = ST_DIVI;
        end else begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.op = ictc_pkg::OP_READ;
        state_d  = ST_WAIT;
      end
      ST_WAIT: begin
        if (status_i.bit_q) begin
          valid_d = 1'b1;
          poss_d  = 1'b1;
          deg_d   = 1'b0;
          state_d = ST_IDLE;
        end else begin
          miss = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // advance to the next sign combination, or give up after the last one
    if (miss) begin
      cnt_d = 3'd0;
      if (first_q) begin
        first_d = 1'b0;
        m_d     = 6'd0;
        state_d = ST_PERT;
      end else if (m_q == 6'd63) begin
        valid_d = 1'b1;
        poss_d  = 1'b0;
        deg_d   = 1'b0;
        state_d = ST_IDLE;
      end else begin
        m_d     = m_q + 6'd1;
        state_d = ST_PERT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= 3'd0;
      k_q     <= '0;
      axis_q  <= 1'b0;
      m_q     <= 6'd0;
      first_q <= 1'b0;
      valid_q <= 1'b0;
      poss_q  <= 1'b0;
      deg_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      k_q     <= k_d;
      axis_q  <= axis_d;
      m_q     <= m_d;
      first_q <= first_d;
      valid_q <= valid_d;
      poss_q  <= poss_d;
      deg_q   <= deg_d;
    end
  end

  assign busy               = (state_q != ST_IDLE);
  assign valid_o            = valid_q;
  assign possible_o         = poss_q;
  assign degenerate_input_o = deg_q;

endmodule

/* hw/rtl/ictc_dp.sv */
// Datapath of the illumination change table check: config registers,
// channel perturbation, shared multiplier, restoring divider and jump table.
// Depends on ictc_pkg.
`timescale 1ns / 1ps

module ictc_dp #(
  parameter int MAX_STEPS = 512
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  input  logic [ictc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ictc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             kind_i,
  input  logic [8:0]                       table_row_i,
  input  logic [8:0]                       table_col_i,
  input  logic                             table_bit_i,
  input  logic [ictc_pkg::RAW_W-1:0]       red_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]       green_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]       blue_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]       red_unlit_i,
  input  logic [ictc_pkg::RAW_W-1:0]       green_unlit_i,
  input  logic [ictc_pkg::RAW_W-1:0]       blue_unlit_i,
  input  ictc_pkg::cmd_t                   cmd_i,
  output ictc_pkg::status_t                status_o
);

  localparam int SW    = $clog2(MAX_STEPS + 1);
  localparam int IW    = $clog2(MAX_STEPS);
  localparam int AW    = $clog2(MAX_STEPS * MAX_STEPS);
  localparam int DEPTH = MAX_STEPS * MAX_STEPS;
  localparam int PW    = ictc_pkg::PROD_W;
  localparam int NW    = PW + SW;
  localparam int CH_W  = ictc_pkg::CH_W;
  localparam int SUM_W = ictc_pkg::SUM_W;

  // configuration
  logic [ictc_pkg::STEPS_CFG_W-1:0] steps_cfg_q;
  logic [ictc_pkg::ERR_W-1:0]       err_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_cfg_q <= ictc_pkg::STEPS_RESET;
      err_cfg_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        ictc_pkg::REG_TABLE_STEPS: steps_cfg_q <= cfg_data_i[ictc_pkg::STEPS_CFG_W-1:0];
        ictc_pkg::REG_REL_ERROR:   err_cfg_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // per-query working registers
  logic [ictc_pkg::RAW_W-1:0] raw_q [ictc_pkg::NCH];
  logic [CH_W-1:0]            c_q   [ictc_pkg::NCH];
  logic [ictc_pkg::ERR_W-1:0] e_q;
  logic [SW-1:0]              steps_q;
  logic [SUM_W-1:0]           sl_q, su_q;
  logic [PW-1:0]              rn_q, rd_q, gn_q, gd_q;
  logic [NW-1:0]              rem_q;
  logic [PW-1:0]              den_q;
  logic [SW-1:0]              quo_q;
  logic [IW-1:0]              i_q, j_q;
  logic                       rdata_q;

  // steps clamped to [1, MAX_STEPS]
  logic [10:0]   steps_wide;
  logic [SW-1:0] steps_eff;
  always_comb begin
    steps_wide = {1'b0, steps_cfg_q};
    if (steps_wide == 11'd0) begin
      steps_eff = SW'(1);
    end else if (steps_wide > 11'(MAX_STEPS)) begin
      steps_eff = SW'(MAX_STEPS);
    end else begin
      steps_eff = SW'(steps_wide);
    end
  end

  // perturbation of one channel
  logic                       up;
  logic [ictc_pkg::FACT_W-1:0] fact;
  logic [32:0]                pprod;
  logic [32:0]                pround;
  logic [CH_W-1:0]            c_new;
  always_comb begin
    case (cmd_i.idx)
      3'd0:    up = cmd_i.mask[5];
      3'd1:    up = cmd_i.mask[3];
      3'd2:    up = cmd_i.mask[1];
      3'd3:    up = cmd_i.mask[4];
      3'd4:    up = cmd_i.mask[2];
      default: up = cmd_i.mask[0];
    endcase
    fact   = up ? (ictc_pkg::ONE_Q16 + {1'b0, e_q}) : (ictc_pkg::ONE_Q16 - {1'b0, e_q});
    pprod  = 33'(raw_q[cmd_i.idx]) * 33'(fact);
    pround = pprod + ictc_pkg::ROUND_HALF;
    if (cmd_i.first) begin
      c_new = {1'b0, raw_q[cmd_i.idx], 8'h00};
    end else begin
      c_new = pround[32:8];
    end
  end

  // shared cross-product multiplier
  logic [CH_W-1:0]       mul_a;
  logic [SUM_W-1:0]      mul_b;
  logic [PW-1:0]         mprod;
  always_comb begin
    case (cmd_i.idx)
      3'd0:    begin mul_a = c_q[0]; mul_b = su_q; end
      3'd1:    begin mul_a = c_q[3]; mul_b = sl_q; end
      3'd2:    begin mul_a = c_q[1]; mul_b = su_q; end
      default: begin mul_a = c_q[4]; mul_b = sl_q; end
    endcase
    mprod = PW'(mul_a) * PW'(mul_b);
  end

  // divider
  logic [NW-1:0] dinit;
  logic [NW-1:0] dtrial;
  logic [NW:0]   rem2;
  logic          round_up;
  logic [SW:0]   qround;
  logic [SW:0]   qclamp;
  always_comb begin
    dinit    = NW'(cmd_i.axis ? gn_q : rn_q) * NW'(steps_q);
    dtrial   = NW'(den_q) << cmd_i.k;
    rem2     = {rem_q, 1'b0};
    round_up = (rem2 >= (NW + 1)'(den_q));
    qround   = (SW + 1)'(quo_q) + (SW + 1)'(round_up);
    if (qround >= (SW + 1)'(steps_q)) begin
      qclamp = (SW + 1)'(steps_q) - 1'b1;
    end else begin
      qclamp = qround;
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      ictc_pkg::OP_LOAD: begin
        raw_q[0] <= red_lit_i;
        raw_q[1] <= green_lit_i;
        raw_q[2] <= blue_lit_i;
        raw_q[3] <= red_unlit_i;
        raw_q[4] <= green_unlit_i;
        raw_q[5] <= blue_unlit_i;
        e_q      <= err_cfg_q;
        steps_q  <= steps_eff;
      end
      ictc_pkg::OP_PERT: begin
        c_q[cmd_i.idx] <= c_new;
      end
      ictc_pkg::OP_SUM: begin
        sl_q <= SUM_W'(c_q[0]) + SUM_W'(c_q[1]) + SUM_W'(c_q[2]);
        su_q <= SUM_W'(c_q[3]) + SUM_W'(c_q[4]) + SUM_W'(c_q[5]);
      end
      ictc_pkg::OP_MUL: begin
        case (cmd_i.idx)
          3'd0:    rn_q <= mprod << 1;
          3'd1:    rd_q <= (mprod << 3) + mprod;
          3'd2:    gn_q <= mprod;
          default: gd_q <= mprod << 1;
        endcase
      end
      ictc_pkg::OP_DIVINIT: begin
        rem_q <= dinit;
        den_q <= cmd_i.axis ? gd_q : rd_q;
        quo_q <= '0;
      end
      ictc_pkg::OP_DIVSTEP: begin
        if (rem_q >= dtrial) begin
          rem_q <= rem_q - dtrial;
          quo_q <= quo_q | (SW'(1) << cmd_i.k);
        end
      end
      ictc_pkg::OP_DIVEND: begin
        if (cmd_i.axis) begin
          j_q <= IW'(qclamp);
        end else begin
          i_q <= IW'(qclamp);
        end
      end
      default: ;
    endcase
  end

  // jump table
  logic          mem [DEPTH];
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;

  assign wr_en   = (cmd_i.op == ictc_pkg::OP_LOAD) && !kind_i &&
                   ({2'b00, table_row_i} < 11'(MAX_STEPS)) &&
                   ({2'b00, table_col_i} < 11'(MAX_STEPS));
  assign wr_addr = AW'(table_row_i) * AW'(MAX_STEPS) + AW'(table_col_i);
  assign rd_addr = AW'(i_q) * AW'(MAX_STEPS) + AW'(j_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= table_bit_i;
    end
    if (cmd_i.op == ictc_pkg::OP_READ) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign status_o.zero   = (sl_q == '0) || (c_q[3] == '0) || (c_q[4] == '0);
  assign status_o.reject = (rn_q > rd_q) || (gn_q > gd_q);
  assign status_o.bit_q  = rdata_q;

endmodule

/* hw/rtl/ictc_checker.sv */
// Port-level checker for the illumination change table check, with its bind.
// Depends on illum_change_table_check only through its ports.
`timescale 1ns / 1ps

module ictc_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic kind_i,
  input logic valid_o,
  input logic possible_o,
  input logic degenerate_input_o
);

  // a table write finishes in its own beat
  a_write_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && !kind_i |=> !busy && !valid_o)
    else $error("table write left the block busy or made a result");

  // a query occupies the block
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && kind_i |=> busy)
    else $error("query accepted without going busy");

  // a result shows once, after the query is done
  a_result_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy ##1 !valid_o)
    else $error("result strobe while busy or longer than one cycle");

  // degenerate input never reports a hit
  a_degenerate_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && degenerate_input_o |-> !possible_o)
    else $error("degenerate query reported possible");

endmodule

bind illum_change_table_check ictc_checker u_ictc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .kind_i            (kind_i),
  .valid_o           (valid_o),
  .possible_o        (possible_o),
  .degenerate_input_o(degenerate_input_o)
);

/* tb/illum_change_table_check_scoreboard.sv */
// Checker for the illumination change table check: watches the command,
// result and config channels, predicts each query answer and compares.
// Depends on ictc_pkg for field widths and register indexes.
`timescale 1ns / 1ps

module illum_change_table_check_scoreboard (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            kind_i,
  input  logic [8:0]                      table_row_i,
  input  logic [8:0]                      table_col_i,
  input  logic                            table_bit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      red_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      green_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      blue_lit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      red_unlit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      green_unlit_i,
  input  logic [ictc_pkg::RAW_W-1:0]      blue_unlit_i,
  input  logic                            valid_o,
  input  logic                            possible_o,
  input  logic                            degenerate_input_o,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [ictc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [ictc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              answers_owed_o,
  output int                              fail_count_o
);
  import ictc_pkg::*;

  typedef struct packed {
    logic possible;
    logic degenerate;
  } answer_t;

  localparam int MAX_STEPS = 512;

  logic                   jump_bits [MAX_STEPS*MAX_STEPS];
  logic [STEPS_CFG_W-1:0] steps_q;
  logic [ERR_W-1:0]       err_q;
  answer_t                answers_owed [$];
  int                     fails;

  assign answers_owed_o = answers_owed.size();
  assign fail_count_o   = fails;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fails++;
  endtask

  function automatic logic [127:0] div_nearest(input logic [127:0] n, input logic [127:0] d);
    logic [127:0] q, r;
    q = n / d;
    r = n % d;
    if (r >= d - r) q = q + 1;
    return q;
  endfunction

  // -1 on a zero divisor, else the table bit (0 when a ratio is above one)
  function automatic int ratio_bit(input logic [127:0] ch [6], input int steps);
    logic [127:0] sl, su, rn, rd, gn, gd, i, j;
    sl = ch[0] + ch[1] + ch[2];
    su = ch[3] + ch[4] + ch[5];
    if (sl == 0 || ch[3] == 0 || ch[4] == 0) return -1;
    rn = 2 * ch[0] * su;
    rd = 9 * sl * ch[3];
    gn = ch[1] * su;
    gd = 2 * sl * ch[4];
    if (rn > rd || gn > gd) return 0;
    i = div_nearest(rn * steps, rd);
    j = div_nearest(gn * steps, gd);
    if (i >= steps) i = steps - 1;
    if (j >= steps) j = steps - 1;
    return int'(jump_bits[i * MAX_STEPS + j]);
  endfunction

  function automatic logic [127:0] nudge(input logic [127:0] x, input logic up);
    logic [127:0] f;
    f = up ? 128'(ONE_Q16) + err_q : 128'(ONE_Q16) - err_q;
    return (x * f + 128) >> 8;
  endfunction

  function automatic answer_t judge_jump(input logic [127:0] raw [6]);
    logic [127:0] ch [6];
    int steps, res;
    answer_t a;
    steps = (steps_q == 0) ? 1 : (steps_q > MAX_STEPS) ? MAX_STEPS : int'(steps_q);
    for (int k = 0; k < 6; k++) ch[k] = raw[k] << 8;
    res = ratio_bit(ch, steps);
    a.degenerate = (res < 0);
    a.possible   = (res == 1);
    if (res < 0) return a;
    // sign bits from msb: Rl Ru Gl Gu Bl Bu
    for (int m = 0; m < 64 && !a.possible; m++) begin
      ch[0] = nudge(raw[0], m[5]);
      ch[3] = nudge(raw[3], m[4]);
      ch[1] = nudge(raw[1], m[3]);
      ch[4] = nudge(raw[4], m[2]);
      ch[2] = nudge(raw[2], m[1]);
      ch[5] = nudge(raw[5], m[0]);
      if (ratio_bit(ch, steps) == 1) a.possible = 1'b1;
    end
    return a;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [127:0] raw [6];
    answer_t      want;
    if (!rst_ni) begin
      steps_q <= STEPS_RESET;
      err_q   <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_TABLE_STEPS) steps_q <= cfg_data_i[STEPS_CFG_W-1:0];
        else if (cfg_index_i == REG_REL_ERROR) err_q <= cfg_data_i;
      end
      if (start && !busy) begin
        if (!kind_i) begin
          jump_bits[table_row_i * MAX_STEPS + table_col_i] = table_bit_i;
        end else begin
          raw[0] = red_lit_i;
          raw[1] = green_lit_i;
          raw[2] = blue_lit_i;
          raw[3] = red_unlit_i;
          raw[4] = green_unlit_i;
          raw[5] = blue_unlit_i;
          answers_owed.push_back(judge_jump(raw));
        end
      end
      if (valid_o) begin
        if (answers_owed.size() == 0) begin
          report("answer with none owed");
        end else begin
          want = answers_owed.pop_front();
          if (possible_o !== want.possible)
            report($sformatf("possible %b, want %b", possible_o, want.possible));
          if (degenerate_input_o !== want.degenerate)
            report($sformatf("degenerate %b, want %b", degenerate_input_o, want.degenerate));
        end
      end
    end
  end

  initial fails = 0;

endmodule

/* tb/illum_change_table_check_tb.sv */
// Testbench top for the illumination change table check: drives table loads,
// queries and register writes, and gives the verdict from the checker.
// Depends on ictc_pkg, illum_change_table_check and its scoreboard.
`timescale 1ns / 1ps

module illum_change_table_check_tb;
  import ictc_pkg::*;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  start = 1'b0;
  logic                  busy;
  logic                  kind_i = 1'b0;
  logic [8:0]            table_row_i = '0;
  logic [8:0]            table_col_i = '0;
  logic                  table_bit_i = 1'b0;
  logic [RAW_W-1:0]      red_lit_i = '0, green_lit_i = '0, blue_lit_i = '0;
  logic [RAW_W-1:0]      red_unlit_i = '0, green_unlit_i = '0, blue_unlit_i = '0;
  logic                  valid_o, possible_o, degenerate_input_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  int                    answers_owed;
  int                    fail_count;

  // square of the table loaded so far, rows and cols 0..loaded_span-1
  int loaded_span = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  illum_change_table_check DUT (.*);
  illum_change_table_check_scoreboard u_check (
    .answers_owed_o(answers_owed), .fail_count_o(fail_count), .*);

  // Hold one beat on the command port until it is taken. The gap before the
  // beat is drawn by the caller; with no gap start stays high back to back.
  task automatic send_beat(input logic kind, input logic [8:0] row, input logic [8:0] col,
                           input logic tbit, input logic [RAW_W-1:0] ch [6], input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    kind_i      <= kind;
    table_row_i <= row;
    table_col_i <= col;
    table_bit_i <= tbit;
    red_lit_i   <= ch[0];
    green_lit_i <= ch[1];
    blue_lit_i  <= ch[2];
    red_unlit_i <= ch[3];
    green_unlit_i <= ch[4];
    blue_unlit_i  <= ch[5];
    do @(posedge clk_i); while (busy);
  endtask

  task automatic write_bit(input int row, input int col, input logic tbit, input int gap);
    logic [RAW_W-1:0] ch [6];
    foreach (ch[k]) ch[k] = RAW_W'($urandom);
    send_beat(1'b0, 9'(row), 9'(col), tbit, ch, gap);
  endtask

  task automatic ask(input logic [RAW_W-1:0] ch [6], input int gap);
    send_beat(1'b1, 9'($urandom), 9'($urandom), 1'($urandom), ch, gap);
  endtask

  // Drop start, let every owed answer arrive and the block settle.
  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (answers_owed != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
  endtask

  // Fill the square that the steps in use can reach, so no query ever
  // reads an entry that was never written. Load back to back.
  task automatic load_span(input int span);
    if (span <= loaded_span) return;
    for (int r = 0; r < span; r++)
      for (int c = 0; c < span; c++)
        if (r >= loaded_span || c >= loaded_span) write_bit(r, c, 1'($urandom), 0);
    loaded_span = span;
    start <= 1'b0;
  endtask

  // Colors: mostly a lit color near a scaled copy of the unlit one, so
  // ratios land inside the table; the rest fully random or with zeros.
  function automatic void pick_colors(output logic [RAW_W-1:0] ch [6]);
    int shape, base;
    shape = $urandom_range(0, 9);
    for (int k = 3; k < 6; k++) ch[k] = RAW_W'($urandom);
    if (shape < 6) begin
      base = $urandom_range(0, 3);
      for (int k = 0; k < 3; k++)
        ch[k] = RAW_W'((ch[k+3] >> base) + $urandom_range(0, 255) - 128);
      if ($urandom_range(0, 3) == 0) ch[0] = ch[0] << 1;
    end else if (shape < 8) begin
      for (int k = 0; k < 3; k++) ch[k] = RAW_W'($urandom);
    end else begin
      for (int k = 0; k < 6; k++) ch[k] = ($urandom_range(0, 2) == 0) ? '0 :
                                          RAW_W'($urandom_range(0, 15));
    end
  endfunction

  function automatic int span_of(input int steps);
    return (steps == 0) ? 1 : (steps > 512) ? 512 : steps;
  endfunction

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [RAW_W-1:0] ch [6];
    int steps_set [6] = '{0, 8, 16, 1, 12, 16};
    int err_set   [6];
    int per_phase;
    err_set = '{0, $urandom_range(1, 8000), 65535, $urandom_range(0, 65535), 0, 655};
    per_phase = 52;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: three table corners and both bit values.
    write_bit(511, 511, 1'b1, 0);
    write_bit(511, 0, 1'b0, 1);
    write_bit(0, 511, 1'b1, 0);
    go_idle();

    for (int p = 0; p < 6; p++) begin
      set_reg(REG_TABLE_STEPS, steps_set[p]);
      set_reg(REG_REL_ERROR, err_set[p]);
      load_span(span_of(steps_set[p]));
      if (p == 0) begin
        // degenerate: all zero, lit sum zero, unlit red zero, unlit green zero; then full-scale and lopsided colors
        ch = '{0, 0, 0, 0, 0, 0};            ask(ch, 0);
        ch = '{0, 0, 0, 5, 5, 5};            ask(ch, 1);
        ch = '{5, 5, 5, 0, 5, 5};            ask(ch, 0);
        ch = '{5, 5, 5, 5, 0, 5};            ask(ch, 2);
        ch = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        ask(ch, 0);
        ch = '{16'hFFFF, 1, 1, 1, 16'hFFFF, 16'hFFFF};  ask(ch, 0);
        ch = '{1, 16'hFFFF, 0, 16'hFFFF, 1, 0};          ask(ch, 3);
      end
      if (p == 2) begin
        // full-scale error: perturbed down channels round to zero
        ch = '{1, 1, 1, 1, 1, 1};  ask(ch, 0);
        ch = '{1, 2, 0, 2, 1, 0};  ask(ch, 0);
      end
      for (int n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 2) == 0) begin
          // rewrite within the loaded square mostly, anywhere now and then
          if ($urandom_range(0, 4) == 0)
            write_bit($urandom_range(0, 511), $urandom_range(0, 511), 1'($urandom),
                      $urandom_range(0, 6));
          else
            write_bit($urandom_range(0, loaded_span - 1), $urandom_range(0, loaded_span - 1),
                      1'($urandom), (n % 32 < 8) ? 0 : $urandom_range(0, 6));
        end else begin
          pick_colors(ch);
          ask(ch, (n % 32 < 8) ? 0 : $urandom_range(0, 6));
        end
      end
      go_idle();
    end

    repeat (50) @(posedge clk_i);
    if (fail_count == 0 && answers_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
